FILE: design/timestamp_aligned_sample_interpolator_core_defines.svh
// Assertion macros shared by the sample interpolator RTL.
// Define ASSERT_OFF to compile the assertions out; no other dependencies.
`ifndef TIMESTAMP_ALIGNED_SAMPLE_INTERPOLATOR_CORE_DEFINES_SVH
`define TIMESTAMP_ALIGNED_SAMPLE_INTERPOLATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Concurrent check on an explicit clock and reset
`define TSAI_ASSERT_CLK(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
// Concurrent check on the module's clk and rst
`define TSAI_ASSERT(lbl, prop, msg) \
  `TSAI_ASSERT_CLK(lbl, clk, rst, prop, msg)
`else
`define TSAI_ASSERT_CLK(lbl, clk_s, rst_s, prop, msg)
`define TSAI_ASSERT(lbl, prop, msg)
`endif

`endif

FILE: design/tsai_pkg.sv
// Shared types, widths, codes and helpers for the timestamped sample interpolator.
// Used by tsai_lerp_lane and the top level; no dependencies.
package tsai_pkg;

  localparam int MOTORS         = 6;
  localparam int SPEED_W        = 16;
  localparam int TIME_W         = 48;
  localparam int GAP_W          = 20;
  localparam int SPD_VEC_W      = MOTORS * SPEED_W;
  localparam int IN_DATA_W      = TIME_W + SPD_VEC_W;
  localparam int STATUS_W       = 2;
  localparam int MAG_W          = SPEED_W;
  localparam int BIT_IDX_W      = $clog2(MAG_W);
  localparam int QUO_W          = MAG_W + 1;
  localparam int EXT_W          = SPEED_W + 3;
  localparam int RING_DEPTH_DEF = 32;

  localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(1);

  // Result kinds carried on the output tuser
  localparam logic [STATUS_W-1:0] STATUS_INTERP = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NEWEST = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_PUSHED = 2'd3;

  // Item kinds carried on the input tuser
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [SPD_VEC_W-1:0] spd_vec_t;

  // Sequencer to interpolation lane controls
  typedef struct packed {
    logic                 init;
    logic                 step;
    logic                 phase;
    logic [BIT_IDX_W-1:0] bit_idx;
  } lane_ctrl_t;

  // Clamp a widened signed value to int16
  function automatic logic signed [SPEED_W-1:0] sat16(input logic signed [EXT_W-1:0] v);
    logic signed [SPEED_W-1:0] r;
    if (v > EXT_W'(32767)) begin
      r = 16'sh7FFF;
    end else if (v < -EXT_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[SPEED_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: design/timestamp_aligned_sample_interpolator_core.sv
// Timestamped six-motor speed ring with linear interpolation at a query time.
// Depends on tsai_pkg, tsai_lerp_lane and the defines header.
//
// Input channel s_axis: tuser is the item kind (push or query), tdata carries
// the timestamp in microseconds and six signed motor speeds. A push stores a
// record, overwriting the oldest one once the ring holds RING_DEPTH records,
// and answers with status "pushed". A query answers with the speeds at the
// given time, the newest record, or zeros for an empty ring.
// Output channel m_axis: tuser is the status, tdata the six speeds.
// Configuration: cfg_we writes cfg_wdata into the minimum interpolation gap.
//
// One item is worked on at a time. A push passes through the emit state
// before the next accept. A query answered from the newest record reads and
// checks it; a search that walks k older records adds, per record, one read
// of the single record memory port, then a compare, and an interpolation
// adds a setup, a gap check, a bit-serial divide in six parallel lanes with
// two half-steps per quotient bit, and a final step.
// Results sit in an output register: the next item is accepted while a result
// waits; a stalled receiver holds the block only when a second result is ready.
// Synchronous reset empties the ring and sets the gap to 1; no clearing pass.

`include "timestamp_aligned_sample_interpolator_core_defines.svh"

module timestamp_aligned_sample_interpolator_core #(
  parameter int RING_DEPTH = tsai_pkg::RING_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tsai_pkg::GAP_W-1:0]         cfg_wdata,     // min_gap_ticks
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // sample_time[47:0], speed_0 .. speed_5 (16 bits each) from bit 48 up
  input  logic [tsai_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  logic                               s_axis_tuser,  // op
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // out_speed_0 .. out_speed_5 (16 bits each) from bit 0 up
  output logic [tsai_pkg::SPD_VEC_W-1:0]     m_axis_tdata,
  output logic [tsai_pkg::STATUS_W-1:0]      m_axis_tuser   // status
);
  import tsai_pkg::*;

  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(RING_DEPTH);

  // Sequencer states
  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_RD_NEWEST  = 4'd1;
  localparam logic [3:0] S_CHK_NEWEST = 4'd2;
  localparam logic [3:0] S_SCAN_RD    = 4'd3;
  localparam logic [3:0] S_SCAN_CHK   = 4'd4;
  localparam logic [3:0] S_SETUP      = 4'd5;
  localparam logic [3:0] S_GAP        = 4'd6;
  localparam logic [3:0] S_DIV        = 4'd7;
  localparam logic [3:0] S_FIN        = 4'd8;
  localparam logic [3:0] S_EMIT       = 4'd9;

  logic [3:0]           state;
  logic [CNT_W-1:0]     count;
  logic [IDX_W-1:0]     oldest;
  logic [IDX_W-1:0]     idx;
  logic [GAP_W-1:0]     gap;
  logic                 phase;
  logic [BIT_IDX_W-1:0] bit_idx;
  logic                 m_valid;

  logic [TIME_W-1:0]    q_time;
  logic [TIME_W-1:0]    ta;
  logic [TIME_W-1:0]    tb;
  logic [TIME_W-1:0]    d_r;
  logic [TIME_W-1:0]    n_r;
  spd_vec_t             a_spd;
  spd_vec_t             b_spd;
  spd_vec_t             newest_spd;
  logic [STATUS_W-1:0]  res_status;
  spd_vec_t             res_spd;
  spd_vec_t             lerp_spd;
  spd_vec_t             m_data;
  logic [STATUS_W-1:0]  m_user;

  logic [TIME_W-1:0]    time_mem [RING_DEPTH];
  spd_vec_t             spd_mem  [RING_DEPTH];
  logic [TIME_W-1:0]    rd_time;
  spd_vec_t             rd_spd;

  logic                 in_acc;
  logic                 push_acc;
  logic                 full;
  logic [CNT_W-1:0]     cnt_m1;
  logic [IDX_W-1:0]     idx_m1;
  logic [IDX_W-1:0]     wr_slot;
  logic [IDX_W-1:0]     rd_addr;
  logic                 out_free;
  logic                 gap_small;
  logic                 div_last;
  lane_ctrl_t           lane_ctrl;

  // Map a position counted from the oldest record to a ring slot
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                              input logic [IDX_W-1:0] lg);
    logic [IDX_W:0] s;
    s = {1'b0, base} + {1'b0, lg};
    if (s >= (IDX_W+1)'(RING_DEPTH)) begin
      s = s - (IDX_W+1)'(RING_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign push_acc      = in_acc && (s_axis_tuser == OP_PUSH);
  assign full          = (count == FULL);
  assign cnt_m1        = count - CNT_W'(1);
  assign idx_m1        = idx - IDX_W'(1);
  assign wr_slot       = full ? oldest : slot_of(oldest, count[IDX_W-1:0]);
  assign out_free      = !m_valid || m_axis_tready;
  assign gap_small     = d_r < TIME_W'(gap);
  assign div_last      = phase && (bit_idx == '0);

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = m_data;
  assign m_axis_tuser  = m_user;

  // Pick the read slot: newest record, or the one below the search position
  always_comb begin
    if (state == S_SCAN_RD) begin
      rd_addr = slot_of(oldest, idx_m1);
    end else begin
      rd_addr = slot_of(oldest, cnt_m1[IDX_W-1:0]);
    end
  end

  // Record memories: write on push, registered read every cycle.
  // Read data is used only while a query runs, when no write can happen.
  always_ff @(posedge clk) begin
    if (push_acc) begin
      time_mem[wr_slot] <= s_axis_tdata[TIME_W-1:0];
      spd_mem[wr_slot]  <= s_axis_tdata[IN_DATA_W-1:TIME_W];
    end
    rd_time <= time_mem[rd_addr];
    rd_spd  <= spd_mem[rd_addr];
  end

  // Control: sequencer, ring pointers, gap register, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      oldest  <= '0;
      idx     <= '0;
      gap     <= GAP_RESET;
      phase   <= 1'b0;
      bit_idx <= '0;
      m_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        gap <= cfg_wdata;
      end
      if (state == S_EMIT && out_free) begin
        m_valid <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser == OP_PUSH) begin
              if (full) begin
                oldest <= slot_of(oldest, IDX_W'(1));
              end else begin
                count <= count + CNT_W'(1);
              end
              state <= S_EMIT;
            end else if (count == '0) begin
              state <= S_EMIT;
            end else begin
              state <= S_RD_NEWEST;
            end
          end
        end
        S_RD_NEWEST: begin
          idx   <= cnt_m1[IDX_W-1:0];
          state <= S_CHK_NEWEST;
        end
        S_CHK_NEWEST: begin
          if (q_time < rd_time && count >= CNT_W'(2)) begin
            state <= S_SCAN_RD;
          end else begin
            state <= S_EMIT;
          end
        end
        S_SCAN_RD: begin
          if (idx == '0) begin
            state <= S_EMIT;
          end else begin
            idx   <= idx_m1;
            state <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          state <= (rd_time <= q_time) ? S_SETUP : S_SCAN_RD;
        end
        S_SETUP: begin
          state <= S_GAP;
        end
        S_GAP: begin
          if (gap_small) begin
            state <= S_EMIT;
          end else begin
            phase   <= 1'b0;
            bit_idx <= BIT_IDX_W'(MAG_W - 1);
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          phase <= !phase;
          if (phase) begin
            bit_idx <= bit_idx - BIT_IDX_W'(1);
          end
          if (div_last) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload: query time, bracketing records, result and output register
  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      m_data <= res_spd;
      m_user <= res_status;
    end
    unique case (state)
      S_IDLE: begin
        q_time     <= s_axis_tdata[TIME_W-1:0];
        res_spd    <= '0;
        res_status <= (s_axis_tuser == OP_PUSH) ? STATUS_PUSHED : STATUS_EMPTY;
      end
      S_CHK_NEWEST: begin
        newest_spd <= rd_spd;
        ta         <= rd_time;
        a_spd      <= rd_spd;
        res_spd    <= rd_spd;
        res_status <= STATUS_NEWEST;
      end
      S_SCAN_RD: begin
        res_spd    <= newest_spd;
        res_status <= STATUS_NEWEST;
      end
      S_SCAN_CHK: begin
        if (rd_time <= q_time) begin
          tb    <= rd_time;
          b_spd <= rd_spd;
        end else begin
          ta    <= rd_time;
          a_spd <= rd_spd;
        end
      end
      S_SETUP: begin
        d_r <= ta - tb;
        n_r <= q_time - tb;
      end
      S_GAP: begin
        res_spd    <= b_spd;
        res_status <= STATUS_INTERP;
      end
      S_FIN: begin
        res_spd    <= lerp_spd;
        res_status <= STATUS_INTERP;
      end
      default: begin
      end
    endcase
  end

  assign lane_ctrl.init    = (state == S_GAP) && !gap_small;
  assign lane_ctrl.step    = (state == S_DIV);
  assign lane_ctrl.phase   = phase;
  assign lane_ctrl.bit_idx = bit_idx;

  // One divider lane per motor
  for (genvar m = 0; m < MOTORS; m++) begin : g_lane
    tsai_lerp_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (lane_ctrl),
      .before_spd (b_spd[m*SPEED_W +: SPEED_W]),
      .after_spd  (a_spd[m*SPEED_W +: SPEED_W]),
      .n          (n_r),
      .d          (d_r),
      .result     (lerp_spd[m*SPEED_W +: SPEED_W])
    );
  end

  `TSAI_ASSERT(a_count_max, count <= FULL, "record count above ring depth")
  `TSAI_ASSERT(a_wrap_only_full, (oldest != '0) |-> full, "oldest slot moved before ring filled")
  `TSAI_ASSERT(a_bracket, (state == S_SETUP) |-> (tb <= q_time && q_time < ta), "bad bracket")

endmodule

FILE: design/tsai_lerp_lane.sv
// One motor's interpolation lane: bit-serial n*|diff|/d with remainder,
// then truncation toward zero and int16 clamp. Depends on tsai_pkg and the defines header.
`include "timestamp_aligned_sample_interpolator_core_defines.svh"

module tsai_lerp_lane (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tsai_pkg::lane_ctrl_t                 ctrl,
  input  logic signed [tsai_pkg::SPEED_W-1:0]  before_spd,
  input  logic signed [tsai_pkg::SPEED_W-1:0]  after_spd,
  input  logic        [tsai_pkg::TIME_W-1:0]   n,
  input  logic        [tsai_pkg::TIME_W-1:0]   d,
  output logic signed [tsai_pkg::SPEED_W-1:0]  result
);
  import tsai_pkg::*;

  logic signed [SPEED_W-1:0] before_r;
  logic                      neg;
  logic [MAG_W-1:0]          mag;
  logic [TIME_W-1:0]         rem_r;
  logic [QUO_W-1:0]          quo;

  logic signed [SPEED_W:0]   diff;
  logic signed [SPEED_W:0]   diff_abs;
  logic [TIME_W:0]           x;
  logic [TIME_W:0]           x_sub;
  logic                      x_ge;
  logic signed [EXT_W-1:0]   base;
  logic signed [EXT_W-1:0]   bse;
  logic signed [EXT_W-1:0]   qe;

  // Signed span between the two records
  assign diff     = (SPEED_W+1)'(after_spd) - (SPEED_W+1)'(before_spd);
  assign diff_abs = diff[SPEED_W] ? -diff : diff;

  // Half step: double the remainder, or add n when this bit of |diff| is set
  always_comb begin
    if (!ctrl.phase) begin
      x = {rem_r, 1'b0};
    end else begin
      x = {1'b0, rem_r} + (mag[ctrl.bit_idx] ? {1'b0, n} : '0);
    end
    x_ge  = x >= {1'b0, d};
    x_sub = x - {1'b0, d};
  end

  // Hold operands and advance the divider
  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      before_r <= before_spd;
      neg      <= diff[SPEED_W];
      mag      <= diff_abs[MAG_W-1:0];
      rem_r    <= '0;
      quo      <= '0;
    end else if (ctrl.step) begin
      rem_r <= x_ge ? x_sub[TIME_W-1:0] : x[TIME_W-1:0];
      if (!ctrl.phase) begin
        quo <= {quo[QUO_W-2:0], 1'b0} + QUO_W'(x_ge);
      end else begin
        quo <= quo + QUO_W'(x_ge);
      end
    end
  end

  // Apply the quotient and truncate toward zero
  always_comb begin
    bse  = EXT_W'(before_r);
    qe   = signed'(EXT_W'(quo));
    base = neg ? (bse - qe) : (bse + qe);
    if (rem_r != '0) begin
      if (!neg && base < 0) begin
        base = base + EXT_W'(1);
      end else if (neg && base > 0) begin
        base = base - EXT_W'(1);
      end
    end
    result = sat16(base);
  end

  `TSAI_ASSERT(a_lane_num_below_den, ctrl.init |-> (n < d), "lane started with n not below d")
  `TSAI_ASSERT(a_lane_rem_below_den, ctrl.step |=> (rem_r < d), "divider remainder reached d")
  `TSAI_ASSERT(a_lane_quo_bound, ctrl.step |=> (quo <= QUO_W'(mag)), "quotient exceeds speed span")

endmodule
